// ===== rtl/cbbn_pkg.sv =====
// shared types, constants and bucketing functions for the coverage bitmap block
package cbbn_pkg;

  // bitmap geometry
  localparam int MAP_BYTES = 65536;
  localparam int MAP_WORDS = MAP_BYTES / 8;
  localparam int ADDR_W    = $clog2(MAP_WORDS);

  // field widths
  localparam int IDX_W  = 13;
  localparam int WORD_W = 64;
  localparam int NOV_W  = 2;
  localparam int CNT_W  = 17;
  localparam int BYTE_CNT_W = 4;

  // saturation limit of both edge counters
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // verdict codes
  localparam logic [NOV_W-1:0] NOV_NONE   = 2'd0;
  localparam logic [NOV_W-1:0] NOV_BUCKET = 2'd1;
  localparam logic [NOV_W-1:0] NOV_EDGE   = 2'd2;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // classified request handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [WORD_W-1:0] word;
    logic              in_range;
    logic              last;
  } cbbn_item_t;

  // one hit-count byte to its power-of-two class
  function automatic logic [7:0] bucket_byte(input logic [7:0] b);
    logic [7:0] r;
    case (b) inside
      [8'd0:8'd2]:     r = b;
      8'd3:            r = 8'd4;
      [8'd4:8'd7]:     r = 8'd8;
      [8'd8:8'd15]:    r = 8'd16;
      [8'd16:8'd31]:   r = 8'd32;
      [8'd32:8'd127]:  r = 8'd64;
      default:         r = 8'd128;
    endcase
    return r;
  endfunction

  // all eight bytes of a word
  function automatic logic [WORD_W-1:0] bucket_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int k = 0; k < WORD_W / 8; k++) begin
      r[8*k +: 8] = bucket_byte(w[8*k +: 8]);
    end
    return r;
  endfunction

endpackage

// ===== rtl/cbbn_ram.sv =====
// generic single-write, single-read ram with registered read (read-first)
module cbbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // storage and registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cbbn_front.sv =====
// front part: takes input requests, buckets the word, checks range and queues them
module cbbn_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbbn_pkg::IDX_W-1:0]     in_word_index,
  input  logic [cbbn_pkg::WORD_W-1:0]    in_hit_word,
  input  logic                           in_run_end,
  input  logic                           clear_busy,
  output logic                           q_valid,
  output cbbn_pkg::cbbn_item_t           q_item,
  input  logic                           q_pop
);

  localparam logic [31:0] MAP_WORDS_32 = 32'(cbbn_pkg::MAP_WORDS);

  cbbn_pkg::cbbn_item_t            q_mem_r [cbbn_pkg::QDEPTH];
  logic [cbbn_pkg::QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [cbbn_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  cbbn_pkg::cbbn_item_t            item_nxt;
  logic                            push;
  logic                            q_full;

  // classify the incoming request
  always_comb begin
    item_nxt.idx      = in_word_index;
    item_nxt.word     = cbbn_pkg::bucket_word(in_hit_word);
    item_nxt.in_range = 32'(in_word_index) < MAP_WORDS_32;
    item_nxt.last     = in_run_end;
  end

  // handshake toward the source
  assign q_full   = cnt_r == cbbn_pkg::QCNT_W'(cbbn_pkg::QDEPTH);
  assign in_stall = clear_busy | q_full;
  assign push     = in_valid & ~in_stall;

  // queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_nxt;
    end
  end

  assign q_valid = cnt_r != '0;
  assign q_item  = q_mem_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cbbn_pkg::QCNT_W'(cbbn_pkg::QDEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != '0)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("request taken while queue full");
`endif

endmodule

// ===== rtl/cbbn_back.sv =====
// back part: virgin map read-modify-write, verdict and counters, output register
module cbbn_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  cbbn_pkg::cbbn_item_t           q_item,
  output logic                           q_pop,
  output logic                           clear_busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbbn_pkg::WORD_W-1:0]    out_bucketed_word,
  output logic [cbbn_pkg::NOV_W-1:0]     out_novelty,
  output logic [cbbn_pkg::CNT_W-1:0]     out_run_edges,
  output logic [cbbn_pkg::CNT_W-1:0]     out_covered_edges,
  output logic                           out_run_done
);

  localparam int AW = cbbn_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(cbbn_pkg::MAP_WORDS - 1);

  // clearing pass state
  logic                          clear_r;
  logic [AW-1:0]                 clr_addr_r;

  // lookup stage
  logic                          b_v_r;
  cbbn_pkg::cbbn_item_t          b_item_r;
  logic                          fwd_hit_r;
  logic [cbbn_pkg::WORD_W-1:0]   fwd_data_r;
  logic                          b_adv;

  // run and map state
  logic [cbbn_pkg::NOV_W-1:0]    nov_r, nov_nxt;
  logic [cbbn_pkg::CNT_W-1:0]    run_cnt_r, run_cnt_nxt;
  logic [cbbn_pkg::CNT_W-1:0]    cov_r, cov_nxt;

  // output register
  logic                          out_valid_r;
  logic [cbbn_pkg::WORD_W-1:0]   out_word_r;
  logic [cbbn_pkg::NOV_W-1:0]    out_nov_r;
  logic [cbbn_pkg::CNT_W-1:0]    out_run_r;
  logic [cbbn_pkg::CNT_W-1:0]    out_cov_r;
  logic                          out_done_r;

  // ram ports
  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [cbbn_pkg::WORD_W-1:0]   ram_wdata, ram_rdata;

  // per-word evaluation
  logic [cbbn_pkg::WORD_W-1:0]   vir, new_vir;
  logic [cbbn_pkg::BYTE_CNT_W-1:0] nz_cnt, fresh_cnt;
  logic                          hit;
  logic [cbbn_pkg::NOV_W-1:0]    verdict;
  logic [cbbn_pkg::CNT_W:0]      run_sum, cov_sum;
  logic                          b_write;

  // pipeline flow control
  assign b_adv      = b_v_r & (~out_valid_r | ~out_stall);
  assign q_pop      = q_valid & ~clear_r & (~b_v_r | b_adv);
  assign b_write    = b_adv & b_item_r.in_range;
  assign clear_busy = clear_r;

  // virgin word, forwarded when the previous request wrote it on the read edge
  assign vir     = fwd_hit_r ? fwd_data_r : ram_rdata;
  assign new_vir = vir & ~b_item_r.word;

  // byte counts and verdict
  always_comb begin
    nz_cnt    = '0;
    fresh_cnt = '0;
    for (int k = 0; k < cbbn_pkg::WORD_W / 8; k++) begin
      if (b_item_r.word[8*k +: 8] != 8'h00) begin
        nz_cnt = nz_cnt + 1'b1;
        if (vir[8*k +: 8] == 8'hff) begin
          fresh_cnt = fresh_cnt + 1'b1;
        end
      end
    end
    hit     = |(b_item_r.word & vir);
    verdict = (fresh_cnt != '0) ? cbbn_pkg::NOV_EDGE : cbbn_pkg::NOV_BUCKET;
  end

  // saturating counter updates and verdict merge
  always_comb begin
    run_sum     = {1'b0, run_cnt_r} + (cbbn_pkg::CNT_W + 1)'(nz_cnt);
    cov_sum     = {1'b0, cov_r} + (cbbn_pkg::CNT_W + 1)'(fresh_cnt);
    nov_nxt     = nov_r;
    run_cnt_nxt = run_cnt_r;
    cov_nxt     = cov_r;
    if (b_item_r.in_range) begin
      if (hit && verdict > nov_r) begin
        nov_nxt = verdict;
      end
      run_cnt_nxt = run_sum[cbbn_pkg::CNT_W] ? cbbn_pkg::CNT_MAX : run_sum[cbbn_pkg::CNT_W-1:0];
      cov_nxt     = cov_sum[cbbn_pkg::CNT_W] ? cbbn_pkg::CNT_MAX : cov_sum[cbbn_pkg::CNT_W-1:0];
    end
  end

  // ram port muxing: clearing pass owns the write port after reset
  assign ram_we    = clear_r | b_write;
  assign ram_waddr = clear_r ? clr_addr_r : AW'(b_item_r.idx);
  assign ram_wdata = clear_r ? '1 : new_vir;
  assign ram_re    = q_pop;
  assign ram_raddr = AW'(q_item.idx);

  cbbn_ram #(
    .WIDTH (cbbn_pkg::WORD_W),
    .DEPTH (cbbn_pkg::MAP_WORDS)
  ) u_virgin (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r     <= 1'b1;
      clr_addr_r  <= '0;
      b_v_r       <= 1'b0;
      fwd_hit_r   <= 1'b0;
      nov_r       <= cbbn_pkg::NOV_NONE;
      run_cnt_r   <= '0;
      cov_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clear_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          clear_r <= 1'b0;
        end
      end
      if (q_pop) begin
        b_v_r     <= 1'b1;
        fwd_hit_r <= b_write && (b_item_r.idx == q_item.idx);
      end else if (b_adv) begin
        b_v_r     <= 1'b0;
        fwd_hit_r <= 1'b0;
      end
      if (b_adv) begin
        cov_r <= cov_nxt;
        if (b_item_r.last) begin
          nov_r     <= cbbn_pkg::NOV_NONE;
          run_cnt_r <= '0;
        end else begin
          nov_r     <= nov_nxt;
          run_cnt_r <= run_cnt_nxt;
        end
      end
      out_valid_r <= b_adv | (out_valid_r & out_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_item_r   <= q_item;
      fwd_data_r <= new_vir;
    end
    if (b_adv) begin
      out_word_r <= b_item_r.word;
      out_nov_r  <= b_item_r.last ? nov_nxt : cbbn_pkg::NOV_NONE;
      out_run_r  <= b_item_r.last ? run_cnt_nxt : '0;
      out_cov_r  <= cov_nxt;
      out_done_r <= b_item_r.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bucketed_word = out_word_r;
  assign out_novelty       = out_nov_r;
  assign out_run_edges     = out_run_r;
  assign out_covered_edges = out_cov_r;
  assign out_run_done      = out_done_r;

`ifndef SYNTHESIS
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !b_v_r && !q_pop)
    else $error("request in flight during clearing pass");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> b_v_r)
    else $error("forward flag without a request in lookup stage");

  a_mid_run_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> out_nov_r == cbbn_pkg::NOV_NONE && out_run_r == '0)
    else $error("run results shown before end of run");

  a_cov_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cov_r >= $past(cov_r))
    else $error("covered count went down");
`endif

endmodule

// ===== rtl/coverage_bitmap_bucket_and_novelty.sv =====
// top level: coverage bitmap bucketing with virgin map novelty check
//
//   channel   direction  handshake            payload
//   in_       input      in_valid / in_stall  in_word_index, in_hit_word, in_run_end
//   out_      output     out_valid/out_stall  out_bucketed_word, out_novelty,
//                                             out_run_edges, out_covered_edges, out_run_done
//
// one request per cycle sustained unless the clearing pass or out_stall holds it;
// an accepted request passes the queue and the lookup stage to the output register
// the virgin map ram has one read and one write port; a same-word request that
// follows directly is served from a forwarding register
// after reset a clearing pass writes all ones over MAP_WORDS (8192) ram words,
// one per cycle, with in_stall high throughout
// a four-entry queue between front and back absorbs output stalls
module coverage_bitmap_bucket_and_novelty (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cbbn_pkg::IDX_W-1:0]     in_word_index,
  input  logic [cbbn_pkg::WORD_W-1:0]    in_hit_word,
  input  logic                           in_run_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbbn_pkg::WORD_W-1:0]    out_bucketed_word,
  output logic [cbbn_pkg::NOV_W-1:0]     out_novelty,
  output logic [cbbn_pkg::CNT_W-1:0]     out_run_edges,
  output logic [cbbn_pkg::CNT_W-1:0]     out_covered_edges,
  output logic                           out_run_done
);

  logic                  q_valid;
  cbbn_pkg::cbbn_item_t  q_item;
  logic                  q_pop;
  logic                  clear_busy;

  // classify and queue
  cbbn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word_index (in_word_index),
    .in_hit_word   (in_hit_word),
    .in_run_end    (in_run_end),
    .clear_busy    (clear_busy),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // map update and results
  cbbn_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bucketed_word (out_bucketed_word),
    .out_novelty       (out_novelty),
    .out_run_edges     (out_run_edges),
    .out_covered_edges (out_covered_edges),
    .out_run_done      (out_run_done)
  );

endmodule

// ===== verif/coverage_bitmap_bucket_and_novelty_tb.sv =====
// testbench for the coverage bitmap bucketing and virgin map novelty block
module coverage_bitmap_bucket_and_novelty_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no request moving on either side before the run is abandoned
  // (well above the clearing pass after reset plus the long hold-off)
  localparam int STALL_LIMIT  = 50000;
  // cycles left after the last result so late extra results show up
  localparam int DRAIN_CYCLES = 16;
  // length of the forced output hold-off
  localparam int HOLD_CYCLES  = 200;

  // one expected result request
  typedef struct {
    logic [cbbn_pkg::WORD_W-1:0] bucketed;
    logic [cbbn_pkg::NOV_W-1:0]  novelty;
    logic [cbbn_pkg::CNT_W-1:0]  run_edges;
    logic [cbbn_pkg::CNT_W-1:0]  covered;
    logic                        run_done;
  } word_verdict_t;

  logic                        clk;
  logic                        rst_n             = 1'b0;
  logic                        in_valid          = 1'b0;
  logic                        in_stall;
  logic [cbbn_pkg::IDX_W-1:0]  in_word_index     = '0;
  logic [cbbn_pkg::WORD_W-1:0] in_hit_word       = '0;
  logic                        in_run_end        = 1'b0;
  logic                        out_valid;
  logic                        out_stall         = 1'b0;
  logic [cbbn_pkg::WORD_W-1:0] out_bucketed_word;
  logic [cbbn_pkg::NOV_W-1:0]  out_novelty;
  logic [cbbn_pkg::CNT_W-1:0]  out_run_edges;
  logic [cbbn_pkg::CNT_W-1:0]  out_covered_edges;
  logic                        out_run_done;

  // predictor state
  logic [cbbn_pkg::WORD_W-1:0] virgin_ref [cbbn_pkg::MAP_WORDS];
  logic [cbbn_pkg::NOV_W-1:0]  run_verdict_ref;
  logic [cbbn_pkg::CNT_W-1:0]  run_edge_ref;
  logic [cbbn_pkg::CNT_W-1:0]  covered_ref;
  word_verdict_t               verdict_q [$];

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asks     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  coverage_bitmap_bucket_and_novelty dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_word_index     (in_word_index),
    .in_hit_word       (in_hit_word),
    .in_run_end        (in_run_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bucketed_word (out_bucketed_word),
    .out_novelty       (out_novelty),
    .out_run_edges     (out_run_edges),
    .out_covered_edges (out_covered_edges),
    .out_run_done      (out_run_done)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hit count to power-of-two class
  function automatic logic [7:0] hit_class(input logic [7:0] b);
    if (b <= 8'd2) return b;
    else if (b == 8'd3) return 8'd4;
    else if (b <= 8'd7) return 8'd8;
    else if (b <= 8'd15) return 8'd16;
    else if (b <= 8'd31) return 8'd32;
    else if (b <= 8'd127) return 8'd64;
    return 8'd128;
  endfunction

  // saturating edge counter step
  function automatic logic [cbbn_pkg::CNT_W-1:0] sat_count(
      input logic [cbbn_pkg::CNT_W-1:0] a, input int n);
    int s;
    s = int'(a) + n;
    if (s > int'(cbbn_pkg::CNT_MAX)) return cbbn_pkg::CNT_MAX;
    return s[cbbn_pkg::CNT_W-1:0];
  endfunction

  // classify one accepted word, update the virgin map and queue the expected result
  task automatic classify_and_mark(input logic [cbbn_pkg::IDX_W-1:0] idx,
                                   input logic [cbbn_pkg::WORD_W-1:0] raw,
                                   input logic last);
    word_verdict_t               r;
    logic [cbbn_pkg::WORD_W-1:0] cls;
    logic [cbbn_pkg::WORD_W-1:0] vir;
    logic [cbbn_pkg::NOV_W-1:0]  verdict;
    int                          nonzero;
    int                          fresh;
    cls = '0;
    for (int k = 0; k < 8; k++) cls[8*k +: 8] = hit_class(raw[8*k +: 8]);
    // words past the end of the map leave all state alone
    if (int'(idx) < cbbn_pkg::MAP_WORDS) begin
      vir = virgin_ref[idx];
      nonzero = 0;
      fresh = 0;
      for (int k = 0; k < 8; k++) begin
        if (cls[8*k +: 8] != 8'd0) begin
          nonzero++;
          if (vir[8*k +: 8] == 8'hff) fresh++;
        end
      end
      if ((cls & vir) != '0) begin
        verdict = (fresh != 0) ? cbbn_pkg::NOV_EDGE : cbbn_pkg::NOV_BUCKET;
        if (verdict > run_verdict_ref) run_verdict_ref = verdict;
      end
      virgin_ref[idx] = vir & ~cls;
      run_edge_ref = sat_count(run_edge_ref, nonzero);
      covered_ref = sat_count(covered_ref, fresh);
    end
    r.bucketed  = cls;
    r.novelty   = last ? run_verdict_ref : cbbn_pkg::NOV_NONE;
    r.run_edges = last ? run_edge_ref : '0;
    r.covered   = covered_ref;
    r.run_done  = last;
    verdict_q = {verdict_q, r};
    // run totals restart after the closing word
    if (last) begin
      run_verdict_ref = cbbn_pkg::NOV_NONE;
      run_edge_ref = '0;
    end
  endtask

  // offer one request, wait until it is taken, then predict it
  task automatic send_word(input logic [cbbn_pkg::IDX_W-1:0] idx,
                           input logic [cbbn_pkg::WORD_W-1:0] raw,
                           input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_word_index <= idx;
    in_hit_word   <= raw;
    in_run_end    <= last;
    do @(posedge clk); while (in_stall);
    classify_and_mark(idx, raw, last);
  endtask

  // output stall: random idling, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [cbbn_pkg::WORD_W-1:0] exp_v,
                             input logic [cbbn_pkg::WORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t %s expected %h actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // compare each result request with the oldest prediction
  always @(posedge clk) begin
    word_verdict_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result expected none actual %h", $realtime,
                 out_bucketed_word);
      end else begin
        e = verdict_q.pop_front();
        check_field("bucketed_word", e.bucketed, out_bucketed_word);
        check_field("novelty", cbbn_pkg::WORD_W'(e.novelty),
                    cbbn_pkg::WORD_W'(out_novelty));
        check_field("run_edges", cbbn_pkg::WORD_W'(e.run_edges),
                    cbbn_pkg::WORD_W'(out_run_edges));
        check_field("covered_edges", cbbn_pkg::WORD_W'(e.covered),
                    cbbn_pkg::WORD_W'(out_covered_edges));
        check_field("run_done", cbbn_pkg::WORD_W'(e.run_done),
                    cbbn_pkg::WORD_W'(out_run_done));
      end
    end
  end

  // watchdog on cycles with no request moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("coverage_bitmap_bucket_and_novelty: mismatch");
        $finish;
      end
    end
  end

  // every bucket boundary, fresh edges
  task automatic test_bucket_classes();
    send_word(13'd0, {8'd15, 8'd8, 8'd7, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0}, 1'b0);
    send_word(13'd1, {8'd0, 8'd5, 8'd255, 8'd128, 8'd127, 8'd32, 8'd31, 8'd16}, 1'b1);
  endtask

  // no new bits, new bucket on a touched byte, empty word
  task automatic test_novelty_verdicts();
    send_word(13'd0, {8'd15, 8'd8, 8'd7, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0}, 1'b1);
    send_word(13'd0, 64'h0000_0000_0000_0200, 1'b1);
    send_word(13'd0, 64'h0, 1'b1);
  endtask

  // last map word, back-to-back same word, alternating bit patterns
  task automatic test_map_edges();
    send_word(13'h1fff, 64'hffff_ffff_ffff_ffff, 1'b0);
    send_word(13'h1fff, 64'h0101_0101_0101_0101, 1'b1);
    send_word(13'h1fff, 64'hffff_ffff_ffff_ffff, 1'b1);
    send_word(13'h1555, 64'h5555_5555_5555_5555, 1'b0);
    send_word(13'h0aaa, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    send_word(13'h0aaa, 64'h0000_0000_0000_0000, 1'b1);
  endtask

  // random runs, mostly on a small set of words so verdicts vary
  task automatic test_random_runs(input int send_pct, input int recv_pct, input int n_items);
    logic [cbbn_pkg::IDX_W-1:0]  idx;
    logic [cbbn_pkg::IDX_W-1:0]  prev_idx;
    logic [cbbn_pkg::IDX_W-1:0]  prev2_idx;
    logic [cbbn_pkg::WORD_W-1:0] raw;
    int                          run_left;
    int                          pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    prev_idx = '0;
    prev2_idx = '0;
    run_left = 0;
    for (int n = 0; n < n_items; n++) begin
      if (run_left == 0) run_left = $urandom_range(24, 1);
      pick = $urandom_range(99);
      if (pick < 15) idx = prev_idx;
      else if (pick < 25) idx = prev2_idx;
      else if (pick < 75) idx = cbbn_pkg::IDX_W'($urandom_range(31));
      else idx = cbbn_pkg::IDX_W'($urandom_range(cbbn_pkg::MAP_WORDS - 1));
      pick = $urandom_range(99);
      if (pick < 8) begin
        raw = {$urandom, $urandom};
      end else if (pick < 13) begin
        raw = '0;
      end else begin
        // sparse bytes of mixed magnitude
        for (int k = 0; k < 8; k++) begin
          pick = $urandom_range(99);
          if (pick < 55) raw[8*k +: 8] = 8'd0;
          else if (pick < 75) raw[8*k +: 8] = 8'($urandom_range(7, 1));
          else if (pick < 90) raw[8*k +: 8] = 8'($urandom_range(127, 8));
          else raw[8*k +: 8] = 8'($urandom_range(255, 128));
        end
      end
      send_word(idx, raw, run_left == 1);
      run_left--;
      prev2_idx = prev_idx;
      prev_idx = idx;
    end
  endtask

  // long output hold-off while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    for (int n = 0; n < 60; n++) begin
      send_word(cbbn_pkg::IDX_W'($urandom_range(15)), {$urandom, $urandom},
                (n % 12) == 11);
    end
  endtask

  // reset, tests in turn, drain and verdict
  initial begin
    for (int w = 0; w < cbbn_pkg::MAP_WORDS; w++) virgin_ref[w] = '1;
    run_verdict_ref = cbbn_pkg::NOV_NONE;
    run_edge_ref = '0;
    covered_ref = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_bucket_classes();
    test_novelty_verdicts();
    test_map_edges();
    test_random_runs(17, 54, 340);
    test_random_runs(54, 17, 340);
    test_random_runs(0, 0, 340);
    test_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("coverage_bitmap_bucket_and_novelty: match");
    end else begin
      $display("coverage_bitmap_bucket_and_novelty: mismatch");
    end
    $finish;
  end

endmodule
